// ===== design/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the priority message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;
  localparam int SLOTS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = 6;
  localparam int PAYLOAD_BYTES = 8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  localparam logic CFG_MAX_MESSAGES = 1'b0;
  localparam logic CFG_MAX_MSG_BYTES = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  prio;
    logic [3:0]  size;
    logic [63:0] data;
    logic [3:0]  cap;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       prio;
    logic [3:0]       size;
    logic [63:0]      data;
    logic [CNT_W-1:0] count;
    logic             not_empty;
  } rsp_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction
endpackage

// ===== design/pmq_front.sv =====
// ----------------------------------------------------------------------------
// pmq_front
// Accepts transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pmq_front import pmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cmd_t        in_cmd,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_take
);
  cmd_t ent_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= in_cmd;
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

// ===== design/pmq_back.sv =====
// ----------------------------------------------------------------------------
// pmq_back
// Executes send and receive: free-slot scan, list walk, slot store.
// ----------------------------------------------------------------------------
module pmq_back import pmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_sel,
  input  logic [5:0]       cfg_data,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_take,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_rsp
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_WALK = 3'd2,
                         S_LINK = 3'd3, S_RECV = 3'd4, S_DONE = 3'd5;

  logic [5:0] max_msg_r;
  logic [3:0] max_bytes_r;
  logic [SLOTS-1:0] free_r;
  logic [SLOTS-1:0] tail_r;
  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic [7:0]  prio_mem [SLOTS];
  logic [3:0]  size_mem [SLOTS];
  logic [63:0] data_mem [SLOTS];
  logic [SLOT_W-1:0] head_r;
  logic [CNT_W-1:0]  qcnt_r;
  logic [2:0] st_r;
  cmd_t cmd_r;
  logic [CNT_W-1:0] idx_r, steps_r;
  logic [SLOT_W-1:0] slot_r, cur_r, prev_r;
  logic have_prev_r;
  logic ovalid_r;
  rsp_t rsp_r;

  logic [CNT_W-1:0] lim;
  logic [3:0] slim;
  assign lim = (max_msg_r < CNT_W'(SLOTS)) ? max_msg_r : CNT_W'(SLOTS);
  assign slim = (max_bytes_r < 4'(PAYLOAD_BYTES)) ? max_bytes_r : 4'(PAYLOAD_BYTES);

  assign q_take = (st_r == S_IDLE) && q_valid && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= 6'd32;
      max_bytes_r <= 4'd8;
      free_r <= '1;
      head_r <= '0;
      qcnt_r <= '0;
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == CFG_MAX_MESSAGES) max_msg_r <= cfg_data;
        else max_bytes_r <= cfg_data[3:0];
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_take) begin
          cmd_r <= q_cmd;
          idx_r <= '0;
          steps_r <= '0;
          cur_r <= head_r;
          have_prev_r <= 1'b0;
          if (q_cmd.op == OP_RECV) begin
            st_r <= (qcnt_r == '0) ? S_DONE : S_RECV;
            rsp_r <= '{status: ST_EMPTY, default: '0};
          end else if (q_cmd.size > slim) begin
            rsp_r <= '{status: ST_SIZE, default: '0};
            st_r <= S_DONE;
          end else if (qcnt_r >= lim) begin
            rsp_r <= '{status: ST_FULL, default: '0};
            st_r <= S_DONE;
          end else begin
            rsp_r <= '0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r >= lim) begin
            rsp_r.status <= ST_FULL;
            st_r <= S_DONE;
          end else if (free_r[idx_r[SLOT_W-1:0]]) begin
            slot_r <= idx_r[SLOT_W-1:0];
            st_r <= S_WALK;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_WALK: begin
          if (steps_r >= qcnt_r || cmd_r.prio > prio_mem[cur_r]) begin
            st_r <= S_LINK;
          end else begin
            prev_r <= cur_r;
            have_prev_r <= 1'b1;
            steps_r <= steps_r + CNT_W'(1);
            if (!tail_r[cur_r]) st_r <= S_LINK;
            else cur_r <= link_mem[cur_r];
          end
        end
        S_LINK: begin
          free_r[slot_r] <= 1'b0;
          prio_mem[slot_r] <= cmd_r.prio;
          size_mem[slot_r] <= cmd_r.size;
          data_mem[slot_r] <= cmd_r.data & byte_mask(cmd_r.size);
          if (have_prev_r) begin
            tail_r[slot_r] <= tail_r[prev_r];
            link_mem[slot_r] <= link_mem[prev_r];
            tail_r[prev_r] <= 1'b1;
            link_mem[prev_r] <= slot_r;
          end else begin
            tail_r[slot_r] <= (qcnt_r != '0);
            link_mem[slot_r] <= head_r;
            head_r <= slot_r;
          end
          qcnt_r <= qcnt_r + CNT_W'(1);
          rsp_r.status <= ST_OK;
          rsp_r.count <= qcnt_r + CNT_W'(1);
          rsp_r.not_empty <= 1'b1;
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_RECV: begin
          if (cmd_r.cap < size_mem[head_r]) begin
            rsp_r.status <= ST_SIZE;
            st_r <= S_DONE;
          end else begin
            rsp_r.status <= ST_OK;
            rsp_r.prio <= prio_mem[head_r];
            rsp_r.size <= size_mem[head_r];
            rsp_r.data <= data_mem[head_r] & byte_mask(size_mem[head_r]);
            rsp_r.count <= qcnt_r - CNT_W'(1);
            rsp_r.not_empty <= (qcnt_r != CNT_W'(1));
            head_r <= tail_r[head_r] ? link_mem[head_r] : '0;
            tail_r[head_r] <= 1'b0;
            free_r[head_r] <= 1'b1;
            qcnt_r <= qcnt_r - CNT_W'(1);
            ovalid_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_DONE: begin
          rsp_r.count <= qcnt_r;
          rsp_r.not_empty <= (qcnt_r != '0);
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// priority_message_queue
// Fixed-pool priority message queue with send and receive transactions.
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// in_      in   valid / stall    op, priority_req, msg_size, payload, receive_capacity
// out_     out  valid / stall    status, priority, size, payload, message_count, not_empty
// cfg_     in   valid / ready    index, data
// A send runs the free-slot scan and the list walk, one slot per cycle each;
// a receive reads the message at the head of the list.
// Synchronous active-low reset; all slots free, queue empty.
// The input queue holds two transactions while the result waits on out_stall.
module priority_message_queue import pmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_priority_req,
  input  logic [3:0]  in_msg_size,
  input  logic [63:0] in_payload,
  input  logic [3:0]  in_receive_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_priority,
  output logic [3:0]  out_size,
  output logic [63:0] out_payload,
  output logic [5:0]  out_message_count,
  output logic        out_not_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  cmd_t in_cmd, q_cmd;
  rsp_t rsp;
  logic q_valid, q_take;

  assign in_cmd = '{op: in_op, prio: in_priority_req, size: in_msg_size,
                    data: in_payload, cap: in_receive_capacity};
  assign cfg_ready = 1'b1;

  pmq_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_cmd,
                     .q_valid, .q_cmd, .q_take);

  pmq_back u_back (.clk, .rst_n, .cfg_we(cfg_valid), .cfg_sel(cfg_index),
                   .cfg_data, .q_valid, .q_cmd, .q_take, .out_valid,
                   .out_stall, .out_rsp(rsp));

  assign out_status = rsp.status;
  assign out_priority = rsp.prio;
  assign out_size = rsp.size;
  assign out_payload = rsp.data;
  assign out_message_count = rsp.count;
  assign out_not_empty = rsp.not_empty;
endmodule

// ===== design/pmq_checker.sv =====
// ----------------------------------------------------------------------------
// pmq_checker
// Port-level checks on the priority message queue.
// ----------------------------------------------------------------------------
module pmq_checker import pmq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [3:0]  out_size,
  input logic [63:0] out_payload,
  input logic [5:0]  out_message_count,
  input logic        out_not_empty
);
  a_ne: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_not_empty == (out_message_count != 6'd0)))
    else $error("not_empty mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");
  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_message_count <= 6'(SLOTS))
    else $error("count overflow");
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload == 64'd0 && out_size == 4'd0)
    else $error("failed result carries data");
endmodule

bind priority_message_queue pmq_checker u_pmq_checker (.*);

// ===== verif/priority_message_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_message_queue_checker
// Watches the send/receive channels and the register port, keeps a model of
// the slot pool and priority list, and compares every result transaction.
// ----------------------------------------------------------------------------
module priority_message_queue_checker import pmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_priority_req,
  input  logic [3:0]  in_msg_size,
  input  logic [63:0] in_payload,
  input  logic [3:0]  in_receive_capacity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_priority,
  input  logic [3:0]  out_size,
  input  logic [63:0] out_payload,
  input  logic [5:0]  out_message_count,
  input  logic        out_not_empty,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  output int          errors,
  output int          pending
);
  logic [5:0]  lim_msgs;
  logic [3:0]  lim_bytes;
  logic        slot_free [SLOTS];
  logic [4:0]  link [SLOTS];
  logic        has_next [SLOTS];
  logic [7:0]  s_prio [SLOTS];
  logic [3:0]  s_size [SLOTS];
  logic [63:0] s_data [SLOTS];
  logic [4:0]  head;
  int          count;
  rsp_t        expected_rsp [$];

  function automatic logic [63:0] keep_bytes(input int n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (i < n) m[i*8 +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic rsp_t queue_step(input cmd_t c);
    rsp_t r;
    int lim, slot, cur, prev, eff_bytes;
    bit found, have_prev;
    r = '0;
    lim = (lim_msgs < SLOTS) ? lim_msgs : SLOTS;
    eff_bytes = (lim_bytes < PAYLOAD_BYTES) ? lim_bytes : PAYLOAD_BYTES;
    if (c.op == OP_SEND) begin
      found = 0;
      slot = 0;
      if (c.size > eff_bytes) r.status = ST_SIZE;
      else if (count >= lim) r.status = ST_FULL;
      else begin
        for (int i = 0; i < lim; i++)
          if (!found && slot_free[i]) begin
            slot = i;
            found = 1;
          end
        if (!found) r.status = ST_FULL;
        else begin
          r.status = ST_OK;
          slot_free[slot] = 1'b0;
          s_prio[slot] = c.prio;
          s_size[slot] = c.size;
          s_data[slot] = c.data & keep_bytes(int'(c.size));
          cur = head;
          prev = 0;
          have_prev = 0;
          for (int k = 0; k < count; k++) begin
            if (c.prio > s_prio[cur]) break;
            prev = cur;
            have_prev = 1;
            if (!has_next[cur]) break;
            cur = link[cur];
          end
          if (have_prev) begin
            has_next[slot] = has_next[prev];
            link[slot] = link[prev];
            has_next[prev] = 1'b1;
            link[prev] = 5'(slot);
          end else begin
            has_next[slot] = (count != 0);
            link[slot] = head;
            head = 5'(slot);
          end
          count++;
        end
      end
    end else if (count == 0) begin
      r.status = ST_EMPTY;
    end else if (c.cap < s_size[head]) begin
      r.status = ST_SIZE;
    end else begin
      r.status = ST_OK;
      r.prio = s_prio[head];
      r.size = s_size[head];
      r.data = s_data[head];
      slot_free[head] = 1'b1;
      cur = head;
      head = has_next[cur] ? link[cur] : '0;
      has_next[cur] = 1'b0;
      count--;
    end
    r.count = CNT_W'(count);
    r.not_empty = (count != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_t c;
    rsp_t e;
    if (!rst_n) begin
      lim_msgs = 6'd32;
      lim_bytes = 4'd8;
      for (int i = 0; i < SLOTS; i++) begin
        slot_free[i] = 1'b1;
        has_next[i] = 1'b0;
      end
      head = '0;
      count = 0;
      errors = 0;
      expected_rsp.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_MESSAGES) lim_msgs = cfg_data;
        else lim_bytes = cfg_data[3:0];
      end
      if (in_valid && !in_stall) begin
        c.op = in_op;
        c.prio = in_priority_req;
        c.size = in_msg_size;
        c.data = in_payload;
        c.cap = in_receive_capacity;
        expected_rsp.push_back(queue_step(c));
      end
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result status %0d", $time, out_status);
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_priority !== e.prio) begin
            $display("%0t: priority exp %0d got %0d", $time, e.prio, out_priority);
            errors++;
          end
          if (out_size !== e.size) begin
            $display("%0t: size exp %0d got %0d", $time, e.size, out_size);
            errors++;
          end
          if (out_payload !== e.data) begin
            $display("%0t: payload exp %h got %h", $time, e.data, out_payload);
            errors++;
          end
          if (out_message_count !== e.count) begin
            $display("%0t: count exp %0d got %0d", $time, e.count, out_message_count);
            errors++;
          end
          if (out_not_empty !== e.not_empty) begin
            $display("%0t: not_empty exp %0d got %0d", $time, e.not_empty,
                     out_not_empty);
            errors++;
          end
        end
      end
      pending = expected_rsp.size();
    end
  end
endmodule

// ===== verif/priority_message_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_message_queue_tb
// Random and directed send/receive traffic under several queue limits,
// with random valid gaps and result stalls; checked by a side model.
// ----------------------------------------------------------------------------
module priority_message_queue_tb;
  import pmq_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_op = OP_SEND;
  logic [7:0]  in_priority_req = '0;
  logic [3:0]  in_msg_size = '0;
  logic [63:0] in_payload = '0;
  logic [3:0]  in_receive_capacity = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_priority;
  logic [3:0]  out_size;
  logic [63:0] out_payload;
  logic [5:0]  out_message_count;
  logic        out_not_empty;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MAX_MESSAGES;
  logic [5:0]  cfg_data = '0;
  int          errors;
  int          pending;
  bit          calm = 0;
  int          idle_cycles = 0;

  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  priority_message_queue u_top (.*);

  priority_message_queue_checker u_chk (.*);

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 37);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] pr, input logic [3:0] sz,
                           input logic [63:0] data, input logic [3:0] cap);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_priority_req <= pr;
    in_msg_size <= sz;
    in_payload <= data;
    in_receive_capacity <= cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] val);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(input int n, input int send_pct);
    logic [3:0] sz;
    for (int i = 0; i < n; i++) begin
      sz = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      if ($urandom_range(99) < send_pct)
        send_item(OP_SEND, 8'($urandom_range(255)), sz, rand64(), 4'($urandom_range(15)));
      else
        send_item(OP_RECV, 8'($urandom), 4'($urandom), rand64(),
                  ($urandom_range(4) == 0) ? 4'($urandom_range(7)) : 4'($urandom_range(8, 15)));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: empty, extremes, equal priority ordering, capacity
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd8);
    send_item(OP_SEND, 8'hFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_item(OP_SEND, 8'h00, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    send_item(OP_SEND, 8'h80, 4'd3, 64'h0123_4567_89AB_CDEF, 4'd0);
    send_item(OP_SEND, 8'h80, 4'd9, 64'h1, 4'd0);
    send_item(OP_SEND, 8'h80, 4'd15, 64'h1, 4'd0);
    send_item(OP_SEND, 8'h80, 4'd5, 64'hAAAA_5555_AAAA_5555, 4'd0);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd7);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd15);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd2);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd3);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd5);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd0);
    send_item(OP_RECV, 8'd0, 4'd0, 64'd0, 4'd0);
    for (int i = 0; i < 33; i++) send_item(OP_SEND, 8'($urandom), 4'd1, rand64(), 4'd0);
    write_reg(CFG_MAX_MESSAGES, 6'd4);
    write_reg(CFG_MAX_MSG_BYTES, 6'd0);
    random_phase(120, 55);
    write_reg(CFG_MAX_MESSAGES, 6'd1);
    write_reg(CFG_MAX_MSG_BYTES, 6'd15);
    random_phase(120, 50);
    write_reg(CFG_MAX_MESSAGES, 6'd63);
    write_reg(CFG_MAX_MSG_BYTES, 6'd3);
    random_phase(250, 60);
    write_reg(CFG_MAX_MESSAGES, 6'd0);
    random_phase(60, 50);
    write_reg(CFG_MAX_MESSAGES, 6'd32);
    write_reg(CFG_MAX_MSG_BYTES, 6'd8);
    calm = 1;
    random_phase(250, 60);
    calm = 0;
    random_phase(300, 52);
    write_reg(CFG_MAX_MESSAGES, 6'd9);
    random_phase(400, 50);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== files.f =====
design/pmq_pkg.sv
design/pmq_front.sv
design/pmq_back.sv
design/priority_message_queue.sv
design/pmq_checker.sv
verif/priority_message_queue_checker.sv
verif/priority_message_queue_tb.sv
